// File: hdl/bmp_pixel_stream_decoder_top_assert.svh
// Assertion macros for the BMP pixel stream decoder.
// Used by bmp_pixel_stream_decoder_top; depends on nothing else.
`ifndef BMP_PIXEL_STREAM_DECODER_TOP_ASSERT_SVH
`define BMP_PIXEL_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bmpd_pkg.sv
// Shared constants, types and helpers of the BMP pixel stream decoder.
// Has no dependencies; the top level refers to it by scoped names.
package bmpd_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int PAL_ENTRIES     = 256;

    localparam int DIM_W           = 13;  // width and height registers
    localparam int COORD_W         = 12;  // column and line outputs
    localparam int PAL_ADDR_W      = 8;
    localparam int ENTRY_CNT_W     = 9;
    localparam int REGION_W        = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_DATA_W      = 56;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_cfg_addr REG_PALETTE_BYTES = 3'd0;
    localparam t_cfg_addr REG_IMAGE_WIDTH   = 3'd1;
    localparam t_cfg_addr REG_IMAGE_HEIGHT  = 3'd2;
    localparam t_cfg_addr REG_BOTTOM_UP     = 3'd3;
    localparam t_cfg_addr REG_DEPTH_MODE    = 3'd4;
    localparam t_cfg_addr REG_EXPAND_PAL    = 3'd5;

    typedef logic [DIM_W-1:0] t_dim;

    // Zero counts as one; anything above the limit saturates.
    function automatic t_dim eff_dim(input t_dim v, input t_dim lim);
        t_dim r;
        if (v == '0) begin
            r = t_dim'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: hdl/bmp_pixel_stream_decoder_top.sv
// BMP pixel stream decoder: palette capture, row/column tracking, pixel output.
// Depends on bmpd_pkg and the assertion macros in bmp_pixel_stream_decoder_top_assert.svh.
// A byte that completes a pixel passes through the decode register, then the output register,
// before m_axis offers it. Throughput: one byte per cycle while m_axis does not back-pressure
// the decode and output registers; the state update and the palette memory read are registered.
// Reset (synchronous, active low) clears all counters and palette valid bits.
`include "bmp_pixel_stream_decoder_top_assert.svh"

module bmp_pixel_stream_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [bmpd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [bmpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // byte stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] stream_byte
    // pixel stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [11:0] column, [23:12] image_line, [31:24] colour_index,
    // [39:32] red, [47:40] green, [55:48] blue
    output logic [bmpd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast   // last_pixel
);

    typedef enum logic [1:0] {
        PH_PALETTE,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    localparam bmpd_pkg::t_dim MAX_W = bmpd_pkg::t_dim'(bmpd_pkg::MAX_WIDTH);
    localparam bmpd_pkg::t_dim MAX_H = bmpd_pkg::t_dim'(bmpd_pkg::MAX_HEIGHT);

    // configuration
    logic [bmpd_pkg::REGION_W-1:0]    r_cfg_palette_bytes;
    bmpd_pkg::t_dim                   r_cfg_width;
    bmpd_pkg::t_dim                   r_cfg_height;
    logic                             r_cfg_bottom_up;
    logic                             r_cfg_mode;
    logic                             r_cfg_expand;

    // decode state
    t_phase                           r_phase,        n_phase;
    logic [bmpd_pkg::REGION_W-1:0]    r_region_count, n_region_count;
    logic [bmpd_pkg::ENTRY_CNT_W-1:0] r_entry_count,  n_entry_count;
    logic [1:0]                       r_byte_phase,   n_byte_phase;
    logic [7:0]                       r_held_blue,    n_held_blue;
    logic [7:0]                       r_held_green,   n_held_green;
    logic [bmpd_pkg::COORD_W-1:0]     r_column_count, n_column_count;
    bmpd_pkg::t_dim                   r_rows_done,    n_rows_done;
    logic [1:0]                       r_pad_left,     n_pad_left;

    // palette memory with per-entry valid bits
    logic [23:0]                      r_pal_mem [bmpd_pkg::PAL_ENTRIES];
    logic [bmpd_pkg::PAL_ENTRIES-1:0] r_pal_vld;
    logic [23:0]                      r_rd_data;
    logic                             r_rd_vld;
    logic                             n_wr_en;
    logic [bmpd_pkg::PAL_ADDR_W-1:0]  n_wr_addr;
    logic [23:0]                      n_wr_data;

    // decode stage register
    logic                             r_a_vld;
    logic [bmpd_pkg::COORD_W-1:0]     r_a_col;
    logic [bmpd_pkg::COORD_W-1:0]     r_a_line;
    logic [7:0]                       r_a_idx;
    logic [23:0]                      r_a_rgb;
    logic                             r_a_use_pal;
    logic                             r_a_last;

    // output register
    logic                             r_o_vld;
    logic [bmpd_pkg::OUT_DATA_W-1:0]  r_o_data;
    logic                             r_o_last;

    logic                             accept;
    logic                             a_move;
    logic                             n_emit;
    logic [bmpd_pkg::COORD_W-1:0]     n_out_line;
    logic [23:0]                      n_out_rgb;
    logic                             n_out_last;
    logic [23:0]                      o_rgb;

    bmpd_pkg::t_dim                   w_eff;
    bmpd_pkg::t_dim                   h_eff;
    bmpd_pkg::t_dim                   col_next;
    bmpd_pkg::t_dim                   row_next;
    bmpd_pkg::t_dim                   line_up;
    logic                             col_end;
    logic                             row_last;
    logic [bmpd_pkg::REGION_W:0]      region_plus3;
    logic [1:0]                       row_pad;

    assign a_move        = !r_o_vld || m_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_a_vld || a_move);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign w_eff    = bmpd_pkg::eff_dim(r_cfg_width, MAX_W);
    assign h_eff    = bmpd_pkg::eff_dim(r_cfg_height, MAX_H);
    assign col_next = bmpd_pkg::t_dim'(r_column_count) + bmpd_pkg::t_dim'(1);
    assign row_next = r_rows_done + bmpd_pkg::t_dim'(1);
    assign col_end  = col_next >= w_eff;
    assign row_last = row_next >= h_eff;
    assign line_up  = h_eff - row_next;
    assign region_plus3 = {1'b0, r_region_count} + (bmpd_pkg::REGION_W+1)'(3);
    // 24-bit rows are 3*w bytes, so their padding is w mod 4; 8-bit rows pad by -w mod 4.
    assign row_pad  = r_cfg_mode ? w_eff[1:0] : (2'd0 - w_eff[1:0]);

    always_comb begin
        logic bp;
        logic pix;
        logic [1:0] bp_cur;

        n_phase        = r_phase;
        n_region_count = r_region_count;
        n_entry_count  = r_entry_count;
        n_byte_phase   = r_byte_phase;
        n_held_blue    = r_held_blue;
        n_held_green   = r_held_green;
        n_column_count = r_column_count;
        n_rows_done    = r_rows_done;
        n_pad_left     = r_pad_left;
        n_wr_en        = 1'b0;
        n_wr_addr      = r_entry_count[bmpd_pkg::PAL_ADDR_W-1:0];
        n_wr_data      = {r_held_blue, r_held_green, s_axis_tdata};
        n_emit         = 1'b0;
        n_out_line     = bmpd_pkg::COORD_W'(0);
        n_out_rgb      = 24'd0;
        n_out_last     = 1'b0;
        bp             = 1'b0;
        pix            = 1'b0;
        bp_cur         = r_byte_phase;

        if (accept) begin
            unique case (r_phase)
                PH_PALETTE: begin
                    if (r_region_count < r_cfg_palette_bytes) begin
                        n_region_count = r_region_count + bmpd_pkg::REGION_W'(1);
                        case (r_byte_phase)
                            2'd0: begin
                                bp = (region_plus3 <= {1'b0, r_cfg_palette_bytes}) &&
                                     (r_entry_count <
                                      bmpd_pkg::ENTRY_CNT_W'(bmpd_pkg::PAL_ENTRIES));
                                if (bp) begin
                                    n_held_blue  = s_axis_tdata;
                                    n_byte_phase = 2'd1;
                                end
                            end
                            2'd1: begin
                                n_held_green = s_axis_tdata;
                                n_byte_phase = 2'd2;
                            end
                            2'd2: begin
                                n_wr_en       = 1'b1;
                                n_entry_count = r_entry_count + bmpd_pkg::ENTRY_CNT_W'(1);
                                n_byte_phase  = 2'd3;
                            end
                            default: begin
                                n_byte_phase = 2'd0;
                            end
                        endcase
                    end else begin
                        // Region exhausted: this byte is already pixel data.
                        n_phase      = PH_PIXELS;
                        n_byte_phase = 2'd0;
                        bp_cur       = 2'd0;
                        pix          = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    pix = 1'b1;
                end
                default: begin
                end
            endcase

            if (pix) begin
                if (r_rows_done >= h_eff) begin
                    n_phase = PH_DONE;
                end else if (r_pad_left != 2'd0) begin
                    n_pad_left = r_pad_left - 2'd1;
                    if (r_pad_left == 2'd1) begin
                        n_column_count = '0;
                        n_rows_done    = row_next;
                        if (row_last) begin
                            n_phase = PH_DONE;
                        end
                    end
                end else if (r_cfg_mode && bp_cur == 2'd0) begin
                    n_held_blue  = s_axis_tdata;
                    n_byte_phase = 2'd1;
                end else if (r_cfg_mode && bp_cur == 2'd1) begin
                    n_held_green = s_axis_tdata;
                    n_byte_phase = 2'd2;
                end else begin
                    n_emit       = 1'b1;
                    n_byte_phase = 2'd0;
                    n_out_rgb    = r_cfg_mode ? {r_held_blue, r_held_green, s_axis_tdata}
                                              : 24'd0;
                    n_out_line   = r_cfg_bottom_up ? line_up[bmpd_pkg::COORD_W-1:0]
                                                   : r_rows_done[bmpd_pkg::COORD_W-1:0];
                    n_out_last   = col_end && row_last;
                    if (col_end) begin
                        n_pad_left = row_pad;
                        if (row_pad == 2'd0) begin
                            n_column_count = '0;
                            n_rows_done    = row_next;
                            if (row_last) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end else begin
                        n_column_count = col_next[bmpd_pkg::COORD_W-1:0];
                    end
                end
            end
        end
    end

    // n_out_rgb is packed {blue, green, red} from the top byte down.
    // Unwritten palette entries read as zero.
    assign o_rgb = !r_a_use_pal ? r_a_rgb : (r_rd_vld ? r_rd_data : 24'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_palette_bytes <= '0;
            r_cfg_width         <= bmpd_pkg::t_dim'(1);
            r_cfg_height        <= bmpd_pkg::t_dim'(1);
            r_cfg_bottom_up     <= 1'b1;
            r_cfg_mode          <= 1'b0;
            r_cfg_expand        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bmpd_pkg::REG_PALETTE_BYTES: r_cfg_palette_bytes <= i_cfg_data;
                bmpd_pkg::REG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg_data[bmpd_pkg::DIM_W-1:0];
                bmpd_pkg::REG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg_data[bmpd_pkg::DIM_W-1:0];
                bmpd_pkg::REG_BOTTOM_UP:     r_cfg_bottom_up <= i_cfg_data[0];
                bmpd_pkg::REG_DEPTH_MODE:    r_cfg_mode      <= i_cfg_data[0];
                bmpd_pkg::REG_EXPAND_PAL:    r_cfg_expand    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PALETTE;
            r_region_count <= '0;
            r_entry_count  <= '0;
            r_byte_phase   <= 2'd0;
            r_held_blue    <= 8'd0;
            r_held_green   <= 8'd0;
            r_column_count <= '0;
            r_rows_done    <= '0;
            r_pad_left     <= 2'd0;
            r_pal_vld      <= '0;
        end else begin
            r_phase        <= n_phase;
            r_region_count <= n_region_count;
            r_entry_count  <= n_entry_count;
            r_byte_phase   <= n_byte_phase;
            r_held_blue    <= n_held_blue;
            r_held_green   <= n_held_green;
            r_column_count <= n_column_count;
            r_rows_done    <= n_rows_done;
            r_pad_left     <= n_pad_left;
            if (n_wr_en) begin
                r_pal_vld[n_wr_addr] <= 1'b1;
            end
        end
    end

    // Writes happen only in the palette region and reads matter only for pixel
    // bytes, so a read never needs the word written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_pal_mem[n_wr_addr] <= n_wr_data;
        end
        if (accept) begin
            r_rd_data <= r_pal_mem[s_axis_tdata];
            r_rd_vld  <= r_pal_vld[s_axis_tdata];
        end
    end

    // Decode stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (a_move) begin
                r_o_vld <= r_a_vld;
            end
            if (accept) begin
                r_a_vld <= n_emit;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_col     <= r_column_count;
            r_a_line    <= n_out_line;
            r_a_idx     <= r_cfg_mode ? 8'd0 : s_axis_tdata;
            r_a_rgb     <= n_out_rgb;
            r_a_use_pal <= !r_cfg_mode && r_cfg_expand;
            r_a_last    <= n_out_last;
        end
        if (a_move && r_a_vld) begin
            r_o_data <= {o_rgb[23:16], o_rgb[15:8], o_rgb[7:0], r_a_idx, r_a_line, r_a_col};
            r_o_last <= r_a_last;
        end
    end

    // r_a_rgb and palette words hold blue in the top byte: {blue, green, red}
    // maps onto tdata as blue[55:48], green[47:40], red[39:32].
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    `BPD_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n,
        r_phase == PH_DONE, r_phase == PH_DONE, "decoder left the finished state")
    `BPD_ASSERT_NEXT(a_no_palette_return, i_clk, i_rst_n,
        r_phase != PH_PALETTE, r_phase != PH_PALETTE, "decoder returned to the palette region")
    `BPD_ASSERT_NOW(a_entry_bound, i_clk, i_rst_n,
        1'b1, r_entry_count <= bmpd_pkg::ENTRY_CNT_W'(bmpd_pkg::PAL_ENTRIES),
        "palette entry count overflow")
    `BPD_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n,
        r_a_vld && r_o_vld && !m_axis_tready, r_a_vld, "decoded pixel dropped under stall")

endmodule

// File: test/tb_bmp_pixel_stream_decoder_top.sv
// Testbench for bmp_pixel_stream_decoder_top: drives palette and pixel bytes, predicts each
// pixel word with its own decoder model and checks the output stream field by field.
// Depends on bmpd_pkg and the RTL of the decoder.
module tb_bmp_pixel_stream_decoder_top;

    localparam int SETTLE_CYCLES  = 8;
    localparam int TOTAL_BYTES    = 1650;
    localparam int DIRECTED_BYTES = 23;
    localparam int RUN_LIMIT      = 2_000_000;

    // Same layout as m_axis_tdata, first member in the highest bits.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  pal_index;
        logic [11:0] line;
        logic [11:0] column;
    } t_pixel_word;

    typedef struct {
        t_pixel_word word;
        logic        last_flag;
    } t_pixel_expect;

    typedef enum logic [1:0] {STG_PALETTE, STG_PIXELS, STG_DONE} t_decode_stage;

    class pixel_scoreboard;
        logic [15:0]   region_len;
        logic [12:0]   width_reg;
        logic [12:0]   height_reg;
        logic          bottom_up_reg;
        logic          rgb_mode;
        logic          expand_reg;
        t_decode_stage stage;
        logic [23:0]   palette [256];
        int unsigned   region_seen;
        int unsigned   entries;
        int unsigned   sub_byte;
        int unsigned   col;
        int unsigned   rows;
        int unsigned   pad;
        logic [7:0]    held_b;
        logic [7:0]    held_g;
        t_pixel_expect pending_pixels[$];
        int unsigned   errors;

        function new();
            region_len    = '0;
            width_reg     = 13'd1;
            height_reg    = 13'd1;
            bottom_up_reg = 1'b1;
            rgb_mode      = 1'b0;
            expand_reg    = 1'b0;
            stage         = STG_PALETTE;
            foreach (palette[i]) palette[i] = '0;
            region_seen   = 0;
            entries       = 0;
            sub_byte      = 0;
            col           = 0;
            rows          = 0;
            pad           = 0;
            held_b        = '0;
            held_g        = '0;
            errors        = 0;
        endfunction

        function void set_reg(bmpd_pkg::t_cfg_addr addr,
                              logic [bmpd_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                bmpd_pkg::REG_PALETTE_BYTES: region_len    = data;
                bmpd_pkg::REG_IMAGE_WIDTH:   width_reg     = data[12:0];
                bmpd_pkg::REG_IMAGE_HEIGHT:  height_reg    = data[12:0];
                bmpd_pkg::REG_BOTTOM_UP:     bottom_up_reg = data[0];
                bmpd_pkg::REG_DEPTH_MODE:    rgb_mode      = data[0];
                bmpd_pkg::REG_EXPAND_PAL:    expand_reg    = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [12:0] v, int unsigned lim);
            if (v == '0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        function void close_row(int unsigned h);
            col = 0;
            pad = 0;
            rows++;
            if (rows >= h) stage = STG_DONE;
        endfunction

        // Advances the decoder by one accepted byte and queues the pixel it completes.
        function void note_byte(logic [7:0] b);
            int unsigned   w;
            int unsigned   h;
            int unsigned   rowbytes;
            logic [23:0]   colour;
            t_pixel_expect px;
            if (stage == STG_DONE) return;
            if (stage == STG_PALETTE) begin
                if (region_seen < region_len) begin
                    case (sub_byte)
                        0: if (region_seen + 3 <= region_len &&
                               entries < bmpd_pkg::PAL_ENTRIES) begin
                            held_b   = b;
                            sub_byte = 1;
                        end
                        1: begin
                            held_g   = b;
                            sub_byte = 2;
                        end
                        2: begin
                            palette[entries % 256] = {b, held_g, held_b};
                            entries++;
                            sub_byte = 3;
                        end
                        default: sub_byte = 0;
                    endcase
                    region_seen++;
                    return;
                end
                stage    = STG_PIXELS;
                sub_byte = 0;
            end

            w = clamp_dim(width_reg, bmpd_pkg::MAX_WIDTH);
            h = clamp_dim(height_reg, bmpd_pkg::MAX_HEIGHT);
            if (rows >= h) begin
                stage = STG_DONE;
                return;
            end
            if (pad > 0) begin
                pad--;
                if (pad == 0) close_row(h);
                return;
            end

            px.word = '0;
            if (rgb_mode) begin
                if (sub_byte == 0) begin
                    held_b   = b;
                    sub_byte = 1;
                    return;
                end
                if (sub_byte == 1) begin
                    held_g   = b;
                    sub_byte = 2;
                    return;
                end
                px.word.red   = b;
                px.word.green = held_g;
                px.word.blue  = held_b;
            end else begin
                px.word.pal_index = b;
                if (expand_reg) begin
                    colour        = palette[b];
                    px.word.red   = colour[23:16];
                    px.word.green = colour[15:8];
                    px.word.blue  = colour[7:0];
                end
            end
            sub_byte = 0;

            px.word.line   = bottom_up_reg ? 12'(h - 1 - rows) : 12'(rows);
            px.word.column = 12'(col);
            px.last_flag   = (col + 1 >= w) && (rows + 1 >= h);
            pending_pixels.push_back(px);

            if (col + 1 >= w) begin
                rowbytes = rgb_mode ? 3 * w : w;
                pad      = (4 - (rowbytes & 3)) & 3;
                if (pad == 0) close_row(h);
            end else begin
                col++;
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) report($sformatf("%s expected %0h, got %0h", name, want, got));
        endfunction

        function void check_pixel(t_pixel_word got, logic got_last);
            t_pixel_expect want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel word %h (last %b) with nothing expected", got, got_last));
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("column", want.word.column, got.column);
            compare_field("image_line", want.word.line, got.line);
            compare_field("colour_index", want.word.pal_index, got.pal_index);
            compare_field("red", want.word.red, got.red);
            compare_field("green", want.word.green, got.green);
            compare_field("blue", want.word.blue, got.blue);
            compare_field("last_pixel", want.last_flag, got_last);
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [bmpd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [bmpd_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata = '0;   // [7:0] stream_byte
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [11:0] column, [23:12] image_line, [31:24] colour_index,
    // [39:32] red, [47:40] green, [55:48] blue
    logic [bmpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tlast;       // last_pixel

    pixel_scoreboard sb;
    bit src_no_gaps = 1'b0;
    bit sink_no_stalls = 1'b0;

    bmp_pixel_stream_decoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // All tasks are entered and left at a falling edge.
    task automatic write_reg(input bmpd_pkg::t_cfg_addr addr, input int unsigned data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = bmpd_pkg::CFG_DATA_W'(data);
        @(posedge i_clk);
        sb.set_reg(addr, bmpd_pkg::CFG_DATA_W'(data));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Leaves tvalid low; a following call without a gap raises it again at the same edge.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits for every expected word, then gives the pipeline time to finish bytes
    // that produce no word before the settings change.
    task automatic wait_idle();
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned region_len;
        int unsigned kind;
        int unsigned sent;
        int unsigned phase_len;
        int unsigned pick;
        int unsigned w_val;
        int unsigned h_val;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Palette region: empty, ending in a short tail, or longer than the store.
        kind = $urandom_range(0, 5);
        if (kind == 0) begin
            region_len = 0;
        end else if (kind <= 2) begin
            region_len = 4 * $urandom_range(1, 200) + $urandom_range(1, 3);
        end else begin
            region_len = 4 * bmpd_pkg::PAL_ENTRIES + $urandom_range(3, 80);
        end
        write_reg(bmpd_pkg::REG_DEPTH_MODE, $urandom_range(0, 1));
        write_reg(bmpd_pkg::REG_PALETTE_BYTES, region_len);
        for (int i = 0; i < region_len; i++) begin
            send_byte(i < 4 ? 8'h00 : (i < 8 ? 8'hFF : 8'($urandom)));
        end

        // Indexed rows of three pixels, expanded then plain, each with one pad byte.
        write_reg(bmpd_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(bmpd_pkg::REG_IMAGE_HEIGHT, 8191);
        write_reg(bmpd_pkg::REG_BOTTOM_UP, 1);
        write_reg(bmpd_pkg::REG_DEPTH_MODE, 0);
        write_reg(bmpd_pkg::REG_EXPAND_PAL, 1);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h55); send_byte(8'hAA);
        wait_idle();
        write_reg(bmpd_pkg::REG_EXPAND_PAL, 0);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'hAA);
        wait_idle();

        // BGR rows of one pixel, three data bytes and one pad byte each.
        write_reg(bmpd_pkg::REG_DEPTH_MODE, 1);
        write_reg(bmpd_pkg::REG_IMAGE_WIDTH, 1);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h77);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h77);
        wait_idle();
        write_reg(bmpd_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(bmpd_pkg::REG_BOTTOM_UP, 0);
        send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h00);
        wait_idle();

        // Leave a BGR pixel half read, then switch to indexed mode.
        send_byte(8'hAB); send_byte(8'hCD);
        wait_idle();
        write_reg(bmpd_pkg::REG_DEPTH_MODE, 0);
        write_reg(bmpd_pkg::REG_EXPAND_PAL, 1);
        send_byte(8'h01);

        // Random phases; the height stays far above the rows that can be reached.
        sent = region_len + DIRECTED_BYTES;
        while (sent < TOTAL_BYTES) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            if (pick == 0) w_val = 0;
            else if (pick == 1) w_val = 4096;
            else if (pick == 2) w_val = 8191;
            else if (pick == 3) w_val = $urandom_range(0, 8191);
            else if (pick <= 6) w_val = $urandom_range(9, 64);
            else w_val = $urandom_range(1, 8);
            pick = $urandom_range(0, 2);
            h_val = (pick == 0) ? 8191 : ((pick == 1) ? 4096 : $urandom_range(2048, 4096));
            write_reg(bmpd_pkg::REG_IMAGE_WIDTH, w_val);
            write_reg(bmpd_pkg::REG_IMAGE_HEIGHT, h_val);
            write_reg(bmpd_pkg::REG_BOTTOM_UP, $urandom_range(0, 1));
            write_reg(bmpd_pkg::REG_DEPTH_MODE, $urandom_range(0, 1));
            write_reg(bmpd_pkg::REG_EXPAND_PAL, $urandom_range(0, 1));
            // The palette length no longer matters once pixel data has begun.
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 2);
                write_reg(bmpd_pkg::REG_PALETTE_BYTES,
                          (pick == 0) ? 0 : ((pick == 1) ? 65535 : $urandom_range(0, 65535)));
            end
            src_no_gaps = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 120);
            repeat (phase_len) send_byte(8'($urandom));
            sent += phase_len;
        end

        // Shrink the image so the current row is the last one, then feed past its end.
        wait_idle();
        src_no_gaps = 1'b0;
        write_reg(bmpd_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 4));
        write_reg(bmpd_pkg::REG_IMAGE_HEIGHT, sb.rows + 1);
        while (sb.stage != STG_DONE) send_byte(8'($urandom));
        repeat (6) send_byte(8'($urandom));
        s_axis_tvalid = 1'b0;
        wait_idle();
        write_reg(bmpd_pkg::REG_IMAGE_HEIGHT, 0);
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);

        if (sb.pending_pixels.size() != 0)
            sb.report($sformatf("%0d expected pixel words never arrived",
                                sb.pending_pixels.size()));
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Output side: random stall before each word, with occasional stall-free stretches.
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) sink_no_stalls = !sink_no_stalls;
            stall = sink_no_stalls ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_pixel(t_pixel_word'(m_axis_tdata), m_axis_tlast);
            @(negedge i_clk);
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
